[design/lacs_pkg.sv]
// Shared types and constants for the LED ambient-cancel sequencer.
// No dependencies; compiled first.
package lacs_pkg;

  // Sequencer phase codes, also shown on the phase_now result field
  typedef enum logic [2:0] {
    PH_INIT    = 3'd0,
    PH_AMBIENT = 3'd1,
    PH_RED     = 3'd2,
    PH_DARK    = 3'd3,
    PH_IR      = 3'd4,
    PH_WAIT    = 3'd5
  } phase_t;

  // Request action codes
  typedef enum logic [1:0] {
    ACT_TICK      = 2'd0,
    ACT_START     = 2'd1,
    ACT_START_RED = 2'd2,
    ACT_STOP      = 2'd3
  } action_t;

  // Register indexes on the APB port (byte address = 4 * index)
  localparam int unsigned REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_SETTLE = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_DARK   = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_PERIOD = 2'd2;
  localparam int unsigned PADDR_W = REG_IDX_W + 2;

  localparam logic [31:0] SETTLE_RESET = 32'd200;
  localparam logic [31:0] DARK_RESET   = 32'd100;
  localparam logic [31:0] PERIOD_RESET = 32'd10000;

  // Field widths
  localparam int unsigned TIME_W = 32;
  localparam int unsigned ADC_W  = 16;
  localparam int unsigned TS_W   = 23;

  // us -> ms: floor(x / 1000) == (x * MS_RECIP) >> MS_SHIFT for any 32-bit x
  localparam logic [28:0] MS_RECIP = 29'd274877907;
  localparam int unsigned MS_SHIFT = 38;

  // LED drive bits
  localparam int unsigned LED_RED_BIT = 0;
  localparam int unsigned LED_IR_BIT  = 1;

  // Timing registers as seen by the sequencer
  typedef struct packed {
    logic [TIME_W-1:0] settle_time_us;
    logic [TIME_W-1:0] dark_gap_us;
    logic [TIME_W-1:0] cycle_period_us;
  } cfg_t;

endpackage

[design/lacs_if.sv]
// Request channel interfaces: tick input and measurement result.
// Depends on lacs_pkg.
interface lacs_in_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   action;
  logic [lacs_pkg::TIME_W-1:0]  now_us;
  logic signed [lacs_pkg::ADC_W-1:0] adc_sample;

  modport source (output valid, output action, output now_us, output adc_sample,
                  input ready);
  modport sink   (input valid, input action, input now_us, input adc_sample,
                  output ready);
endinterface

interface lacs_out_if;
  logic                              valid;
  logic                              ready;
  logic                              led_red_on;
  logic                              led_ir_on;
  logic                              sample_valid;
  logic signed [lacs_pkg::ADC_W-1:0] ambient_value;
  logic signed [lacs_pkg::ADC_W-1:0] red_value;
  logic signed [lacs_pkg::ADC_W-1:0] ir_value;
  logic [lacs_pkg::ADC_W-1:0]        red_corrected;
  logic [lacs_pkg::ADC_W-1:0]        ir_corrected;
  logic [lacs_pkg::TS_W-1:0]         timestamp_ms;
  logic [2:0]                        phase_now;

  modport source (output valid, output led_red_on, output led_ir_on,
                  output sample_valid, output ambient_value, output red_value,
                  output ir_value, output red_corrected, output ir_corrected,
                  output timestamp_ms, output phase_now, input ready);
  modport sink   (input valid, input led_red_on, input led_ir_on,
                  input sample_valid, input ambient_value, input red_value,
                  input ir_value, input red_corrected, input ir_corrected,
                  input timestamp_ms, input phase_now, output ready);
endinterface

[design/led_ambient_cancel_sequencer_top.sv]
// Red/IR LED measurement sequencer with ambient cancellation, top level.
// Depends on lacs_pkg, lacs_in_if/lacs_out_if and lacs_apb_regs.
//
//   channel   | dir | payload
//   ----------+-----+------------------------------------------------------
//   in_ch     | in  | action, now_us, adc_sample
//   out_ch    | out | LED drive, sample_valid, readings, corrected, ms, phase
//   APB       | in  | settle_time_us, dark_gap_us, cycle_period_us
//
// One request accepted per clock while the result is not stalled; each result
// passes the input register, then the sequencer step into the result register.
// The us->ms reciprocal multiply sits in front of the input register; the
// phase compare and ambient subtract sit in front of the result register.
// A stalled result holds both stages; the input register refills as it drains.
// rst is synchronous and returns all sequencer state to init, LEDs off.
module led_ambient_cancel_sequencer_top (
  input  logic                         clk,
  input  logic                         rst,
  lacs_in_if.sink                      in_ch,
  lacs_out_if.source                   out_ch,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lacs_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import lacs_pkg::*;

  cfg_t cfg;

  lacs_apb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // ---------------- input register ----------------
  logic                    in_vld;
  action_t                 in_action;
  logic [TIME_W-1:0]       in_now;
  logic signed [ADC_W-1:0] in_adc;
  logic [TS_W-1:0]         in_ts;
  logic [60:0]             ms_prod;
  logic                    adv;

  assign ms_prod     = 61'(in_ch.now_us) * 61'(MS_RECIP);
  assign adv         = in_vld & (~out_ch.valid | out_ch.ready);
  assign in_ch.ready = ~in_vld | adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld <= in_ch.valid;
    end
    if (in_ch.ready && in_ch.valid) begin
      in_action <= action_t'(in_ch.action);
      in_now    <= in_ch.now_us;
      in_adc    <= in_ch.adc_sample;
      in_ts     <= ms_prod[MS_SHIFT +: TS_W];
    end
  end

  // ---------------- sequencer state ----------------
  phase_t                  phase, phase_next;
  logic                    started, started_next;
  logic                    red_only, red_only_next;
  logic [TIME_W-1:0]       cycle_start, cycle_start_next;
  logic [TIME_W-1:0]       phase_start, phase_start_next;
  logic signed [ADC_W-1:0] amb_rd, amb_rd_next;
  logic signed [ADC_W-1:0] red_rd, red_rd_next;
  logic signed [ADC_W-1:0] ir_rd, ir_rd_next;
  logic [1:0]              led_drive, led_drive_next;
  logic                    done;

  logic [TIME_W-1:0]       phase_el, cycle_el, span;
  logic                    phase_up, cycle_up;
  logic signed [ADC_W:0]   red_diff, ir_diff;
  logic [ADC_W-1:0]        red_corr, ir_corr;

  // wrap-safe elapsed time against the current phase's wait
  assign phase_el = in_now - phase_start;
  assign cycle_el = in_now - cycle_start;
  assign span     = (phase == PH_DARK) ? cfg.dark_gap_us : cfg.settle_time_us;
  assign phase_up = (phase_el >= span);
  assign cycle_up = (cycle_el >= cfg.cycle_period_us);

  // next state for one request
  always_comb begin
    phase_next       = phase;
    started_next     = started;
    red_only_next    = red_only;
    cycle_start_next = cycle_start;
    phase_start_next = phase_start;
    amb_rd_next      = amb_rd;
    red_rd_next      = red_rd;
    ir_rd_next       = ir_rd;
    led_drive_next   = led_drive;
    done             = 1'b0;

    case (in_action)
      ACT_START, ACT_START_RED: begin
        started_next     = 1'b1;
        phase_next       = PH_INIT;
        cycle_start_next = in_now;
        phase_start_next = in_now;
        amb_rd_next      = '0;
        red_rd_next      = '0;
        ir_rd_next       = '0;
        red_only_next    = (in_action == ACT_START_RED);
        led_drive_next   = '0;
      end
      ACT_STOP: begin
        led_drive_next = '0;
        phase_next     = PH_INIT;
        amb_rd_next    = '0;
        red_rd_next    = '0;
        ir_rd_next     = '0;
        red_only_next  = 1'b0;
      end
      default: begin
        if (started) begin
          case (phase)
            PH_INIT: begin
              cycle_start_next = in_now;
              phase_start_next = in_now;
              amb_rd_next      = '0;
              red_rd_next      = '0;
              ir_rd_next       = '0;
              led_drive_next   = '0;
              phase_next       = PH_AMBIENT;
            end
            PH_AMBIENT: begin
              if (phase_up) begin
                amb_rd_next      = in_adc;
                led_drive_next   = 2'b01 << LED_RED_BIT;
                phase_next       = PH_RED;
                phase_start_next = in_now;
              end
            end
            PH_RED: begin
              if (phase_up) begin
                red_rd_next      = in_adc;
                led_drive_next   = '0;
                phase_start_next = in_now;
                if (red_only) begin
                  ir_rd_next = '0;
                  done       = 1'b1;
                  phase_next = PH_WAIT;
                end else begin
                  phase_next = PH_DARK;
                end
              end
            end
            PH_DARK: begin
              if (phase_up) begin
                led_drive_next   = 2'b01 << LED_IR_BIT;
                phase_next       = PH_IR;
                phase_start_next = in_now;
              end
            end
            PH_IR: begin
              if (phase_up) begin
                ir_rd_next       = in_adc;
                led_drive_next   = '0;
                done             = 1'b1;
                phase_next       = PH_WAIT;
                phase_start_next = in_now;
              end
            end
            PH_WAIT: begin
              if (cycle_up) begin
                cycle_start_next = in_now;
                phase_start_next = in_now;
                amb_rd_next      = '0;
                red_rd_next      = '0;
                ir_rd_next       = '0;
                led_drive_next   = '0;
                phase_next       = PH_AMBIENT;
              end
            end
            default: phase_next = PH_INIT;
          endcase
        end
      end
    endcase
  end

  // ambient correction, clamped at zero
  assign red_diff = {red_rd_next[ADC_W-1], red_rd_next} - {amb_rd_next[ADC_W-1], amb_rd_next};
  assign ir_diff  = {ir_rd_next[ADC_W-1], ir_rd_next} - {amb_rd_next[ADC_W-1], amb_rd_next};
  assign red_corr = (red_diff > 0) ? red_diff[ADC_W-1:0] : '0;
  assign ir_corr  = (ir_diff > 0) ? ir_diff[ADC_W-1:0] : '0;

  // state update
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_INIT;
      started     <= 1'b0;
      red_only    <= 1'b0;
      cycle_start <= '0;
      phase_start <= '0;
      amb_rd      <= '0;
      red_rd      <= '0;
      ir_rd       <= '0;
      led_drive   <= '0;
    end else if (adv) begin
      phase       <= phase_next;
      started     <= started_next;
      red_only    <= red_only_next;
      cycle_start <= cycle_start_next;
      phase_start <= phase_start_next;
      amb_rd      <= amb_rd_next;
      red_rd      <= red_rd_next;
      ir_rd       <= ir_rd_next;
      led_drive   <= led_drive_next;
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (adv) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
    if (adv) begin
      out_ch.led_red_on    <= led_drive_next[LED_RED_BIT];
      out_ch.led_ir_on     <= led_drive_next[LED_IR_BIT];
      out_ch.sample_valid  <= done;
      out_ch.ambient_value <= done ? amb_rd_next : '0;
      out_ch.red_value     <= done ? red_rd_next : '0;
      out_ch.ir_value      <= (done && !red_only_next) ? ir_rd_next : '0;
      out_ch.red_corrected <= done ? red_corr : '0;
      out_ch.ir_corrected  <= (done && !red_only_next) ? ir_corr : '0;
      out_ch.timestamp_ms  <= done ? in_ts : '0;
      out_ch.phase_now     <= phase_next;
    end
  end

endmodule

[design/lacs_apb_regs.sv]
// APB register block holding the three timing registers.
// Depends on lacs_pkg.
module lacs_apb_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lacs_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output lacs_pkg::cfg_t                cfg
);
  import lacs_pkg::*;

  logic                 wr_en;
  logic [REG_IDX_W-1:0] idx;

  assign pready = 1'b1;
  assign idx    = paddr[PADDR_W-1:2];
  assign wr_en  = psel & penable & pwrite;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.settle_time_us  <= SETTLE_RESET;
      cfg.dark_gap_us     <= DARK_RESET;
      cfg.cycle_period_us <= PERIOD_RESET;
    end else if (wr_en) begin
      case (idx)
        REG_SETTLE: cfg.settle_time_us  <= pwdata;
        REG_DARK:   cfg.dark_gap_us     <= pwdata;
        REG_PERIOD: cfg.cycle_period_us <= pwdata;
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (idx)
      REG_SETTLE: prdata = cfg.settle_time_us;
      REG_DARK:   prdata = cfg.dark_gap_us;
      REG_PERIOD: prdata = cfg.cycle_period_us;
      default:    prdata = '0;
    endcase
  end

endmodule

[design/lacs_checker.sv]
// Port-level checks on the sequencer top, attached by bind.
// Depends on lacs_pkg and led_ambient_cancel_sequencer_top.
module lacs_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic                             led_red_on,
  input logic                             led_ir_on,
  input logic                             sample_valid,
  input logic [lacs_pkg::ADC_W-1:0]       red_corrected,
  input logic [lacs_pkg::TS_W-1:0]        timestamp_ms,
  input logic [2:0]                       phase_now
);
  import lacs_pkg::*;

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // never both LEDs lit
  a_led_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(led_red_on && led_ir_on))
    else $error("red and IR lit together");

  // a completed cycle leaves the LEDs dark and enters the wait phase
  a_done_wait: assert property (@(posedge clk) disable iff (rst)
    out_valid && sample_valid |-> !led_red_on && !led_ir_on &&
      phase_now == PH_WAIT)
    else $error("completion without LEDs off and wait phase");

  // no completion means zeroed measurement fields
  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !sample_valid |-> red_corrected == '0 && timestamp_ms == '0)
    else $error("measurement fields set without completion");

  // nothing offered right after reset
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind led_ambient_cancel_sequencer_top lacs_checker u_lacs_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .led_red_on    (out_ch.led_red_on),
  .led_ir_on     (out_ch.led_ir_on),
  .sample_valid  (out_ch.sample_valid),
  .red_corrected (out_ch.red_corrected),
  .timestamp_ms  (out_ch.timestamp_ms),
  .phase_now     (out_ch.phase_now)
);
